@@ hdl/swfn_pkg.sv @@
// Package for the sliding window first negative block.
// Holds the shared widths, register codes and ring sizing constants; no dependencies.
package swfn_pkg;

    localparam int DATA_W          = 32;
    localparam int CFG_W           = 7;
    localparam int APB_W           = 32;
    localparam int ADDR_W          = 3;
    localparam int GRP_SIZE        = 32;
    localparam int LOC_W           = 5;
    localparam int RING_SLACK      = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd1;
    localparam logic             REG_WINDOW_SIZE   = 1'b0;

endpackage

@@ hdl/swfn_front.sv @@
// Front end: accepts stream words, keeps write pointer, fill count and sign mask,
// and classifies each word's window into per-group oldest-negative candidates.
// Depends on swfn_pkg.
module swfn_front #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [swfn_pkg::DATA_W-1:0]     sample,
    input  logic                                   push,
    output logic                                   full,
    input  logic        [swfn_pkg::CFG_W-1:0]      window_size,
    output logic                                   ring_we,
    output logic        [$clog2(WINDOW_MAX + swfn_pkg::RING_SLACK)-1:0] ring_waddr,
    output logic                                   q_valid,
    input  logic                                   q_ready,
    output logic [1 + 2 * ((WINDOW_MAX + swfn_pkg::RING_SLACK + swfn_pkg::GRP_SIZE - 1)
                 / swfn_pkg::GRP_SIZE) * (1 + swfn_pkg::LOC_W) - 1:0] q_data
);

    localparam int RING  = WINDOW_MAX + swfn_pkg::RING_SLACK;
    localparam int IDX_W = $clog2(RING);
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (FILL_W > swfn_pkg::CFG_W) ? FILL_W : swfn_pkg::CFG_W;
    localparam int NGRP  = (RING + swfn_pkg::GRP_SIZE - 1) / swfn_pkg::GRP_SIZE;
    localparam int PAD_W = NGRP * swfn_pkg::GRP_SIZE;
    localparam int LOC_W = swfn_pkg::LOC_W;
    localparam int GRP   = swfn_pkg::GRP_SIZE;

    logic                 adv;
    logic                 accept;
    logic [IDX_W-1:0]     wp_reg;
    logic [IDX_W-1:0]     wp_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [RING-1:0]      mask_reg;
    logic [RING-1:0]      mask_next;
    logic [CMP_W-1:0]     ws_ext;
    logic [CMP_W-1:0]     win_cmp;
    logic [FILL_W-1:0]    win;
    logic [IDX_W:0]       end_ext;
    logic [IDX_W:0]       win_ext;
    logic [IDX_W:0]       start_ext;
    logic                 has_result;

    logic                 a_valid_reg;
    logic [RING-1:0]      a_mask_reg;
    logic [IDX_W-1:0]     a_start_reg;
    logic [IDX_W-1:0]     a_end_reg;
    logic                 a_has_reg;

    logic [PAD_W-1:0]     mask_pad;
    logic [PAD_W-1:0]     hi_bits;
    logic [PAD_W-1:0]     lo_bits;
    logic                 wrap;
    logic [NGRP-1:0]              hi_any;
    logic [NGRP-1:0]              lo_any;
    logic [NGRP-1:0][LOC_W-1:0]   hi_loc;
    logic [NGRP-1:0][LOC_W-1:0]   lo_loc;

    logic                         b_valid_reg;
    logic                         b_has_reg;
    logic [NGRP-1:0]              b_hi_any_reg;
    logic [NGRP-1:0]              b_lo_any_reg;
    logic [NGRP-1:0][LOC_W-1:0]   b_hi_loc_reg;
    logic [NGRP-1:0][LOC_W-1:0]   b_lo_loc_reg;

    assign adv        = q_ready;
    assign full       = !adv;
    assign accept     = push && adv;
    assign ring_we    = accept;
    assign ring_waddr = wp_reg;

    always_comb
    begin
        wp_next = (wp_reg == IDX_W'(RING - 1)) ? '0 : wp_reg + 1'b1;
        fill_next = (fill_reg == FILL_W'(WINDOW_MAX)) ? fill_reg : fill_reg + 1'b1;
        mask_next = mask_reg;
        mask_next[wp_reg] = sample[swfn_pkg::DATA_W-1];

        ws_ext = CMP_W'(window_size);
        if (window_size == '0)
            win_cmp = CMP_W'(1);
        else if (ws_ext > CMP_W'(WINDOW_MAX))
            win_cmp = CMP_W'(WINDOW_MAX);
        else
            win_cmp = ws_ext;
        win = win_cmp[FILL_W-1:0];

        end_ext = {1'b0, wp_next};
        win_ext = (IDX_W + 1)'(win);
        if (end_ext >= win_ext)
            start_ext = end_ext - win_ext;
        else
            start_ext = end_ext + (IDX_W + 1)'(RING) - win_ext;
        has_result = fill_next >= win;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
            mask_reg <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_mask_reg  <= mask_next;
            a_start_reg <= start_ext[IDX_W-1:0];
            a_end_reg   <= wp_next;
            a_has_reg   <= has_result;
        end
        if (adv && a_valid_reg)
        begin
            b_has_reg    <= a_has_reg;
            b_hi_any_reg <= hi_any;
            b_lo_any_reg <= lo_any;
            b_hi_loc_reg <= hi_loc;
            b_lo_loc_reg <= lo_loc;
        end
    end

    // split the window into the part from its oldest slot up and the wrapped part
    always_comb
    begin
        mask_pad = PAD_W'(a_mask_reg);
        wrap     = a_start_reg > a_end_reg;
        for (int i = 0; i < PAD_W; i++)
        begin
            hi_bits[i] = mask_pad[i] && (IDX_W'(i) >= a_start_reg)
                         && (wrap || (IDX_W'(i) < a_end_reg));
            lo_bits[i] = mask_pad[i] && wrap && (IDX_W'(i) < a_end_reg);
        end
        for (int g = 0; g < NGRP; g++)
        begin
            hi_any[g] = |hi_bits[g*GRP +: GRP];
            lo_any[g] = |lo_bits[g*GRP +: GRP];
            hi_loc[g] = '0;
            lo_loc[g] = '0;
            for (int i = GRP - 1; i >= 0; i--)
            begin
                if (hi_bits[g*GRP + i])
                    hi_loc[g] = LOC_W'(i);
                if (lo_bits[g*GRP + i])
                    lo_loc[g] = LOC_W'(i);
            end
        end
    end

    assign q_valid = b_valid_reg;
    assign q_data  = {b_has_reg, b_hi_any_reg, b_lo_any_reg, b_hi_loc_reg, b_lo_loc_reg};

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fill_reg != FILL_W'(WINDOW_MAX)) |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count did not advance on an accepted word");

    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> wp_reg == (($past(wp_reg) == IDX_W'(RING - 1)) ? '0 : $past(wp_reg) + 1'b1))
        else $error("write pointer did not advance on an accepted word");

endmodule

@@ hdl/swfn_queue.sv @@
// Two-entry queue between the front end and the back end.
// Generic payload width; depends on swfn_pkg for its depth.
module swfn_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int DEPTH = swfn_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr;
    logic             rd;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            entry_reg[wr_ptr_reg] <= in_data;
    end

endmodule

@@ hdl/swfn_back.sv @@
// Back end: picks the oldest negative slot from the group candidates, reads the value ring
// and holds the result word for the consumer. Depends on swfn_pkg.
module swfn_back #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    output logic                                   q_ready,
    input  logic [1 + 2 * ((WINDOW_MAX + swfn_pkg::RING_SLACK + swfn_pkg::GRP_SIZE - 1)
                 / swfn_pkg::GRP_SIZE) * (1 + swfn_pkg::LOC_W) - 1:0] q_data,
    input  logic                                   ring_we,
    input  logic        [$clog2(WINDOW_MAX + swfn_pkg::RING_SLACK)-1:0] ring_waddr,
    input  logic signed [swfn_pkg::DATA_W-1:0]     ring_wdata,
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   found,
    output logic signed [swfn_pkg::DATA_W-1:0]     first_negative
);

    localparam int RING  = WINDOW_MAX + swfn_pkg::RING_SLACK;
    localparam int IDX_W = $clog2(RING);
    localparam int NGRP  = (RING + swfn_pkg::GRP_SIZE - 1) / swfn_pkg::GRP_SIZE;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int LOC_W = swfn_pkg::LOC_W;

    logic signed [swfn_pkg::DATA_W-1:0] ring_mem [RING];

    logic                         h_has;
    logic [NGRP-1:0]              h_hi_any;
    logic [NGRP-1:0]              h_lo_any;
    logic [NGRP-1:0][LOC_W-1:0]   h_hi_loc;
    logic [NGRP-1:0][LOC_W-1:0]   h_lo_loc;

    logic [GRP_W-1:0]             sel_grp;
    logic [LOC_W-1:0]             sel_loc;
    logic                         pick_found;
    logic [GRP_W+LOC_W-1:0]       rd_full;
    logic [IDX_W-1:0]             rd_addr;

    logic                         deq;
    logic                         load;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         found_reg;
    logic signed [swfn_pkg::DATA_W-1:0] rdata_reg;

    assign {h_has, h_hi_any, h_lo_any, h_hi_loc, h_lo_loc} = q_data;

    // the wrapped part is newer; the upper part wins when it holds a negative
    always_comb
    begin
        sel_grp    = '0;
        sel_loc    = '0;
        pick_found = 1'b0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (h_lo_any[g])
            begin
                sel_grp    = GRP_W'(g);
                sel_loc    = h_lo_loc[g];
                pick_found = 1'b1;
            end
        end
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (h_hi_any[g])
            begin
                sel_grp    = GRP_W'(g);
                sel_loc    = h_hi_loc[g];
                pick_found = 1'b1;
            end
        end
    end

    assign rd_full = {sel_grp, sel_loc};
    assign rd_addr = rd_full[IDX_W-1:0];

    assign q_ready = !out_valid_reg || pop;
    assign deq     = q_valid && q_ready;
    assign load    = deq && h_has;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (deq)
            out_valid_next = h_has;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_waddr] <= ring_wdata;
        if (load)
        begin
            rdata_reg <= ring_mem[rd_addr];
            found_reg <= pick_found;
        end
    end

    assign empty          = !out_valid_reg;
    assign found          = found_reg;
    assign first_negative = found_reg ? rdata_reg : '0;

    a_found_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> rdata_reg[swfn_pkg::DATA_W-1])
        else $error("reported value is not negative");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> out_valid_reg)
        else $error("result word dropped while stalled");

endmodule

@@ hdl/sliding_window_first_negative.sv @@
// Sliding window first negative: for each signed 32-bit stream word, once window_size
// words are held, reports the oldest negative word of the last window_size words.
// Input channel: drive sample with push; the word is taken at a clock edge with push
// high and full low. Result channel: found and first_negative are valid while empty is
// low; the word is taken at a clock edge with pop high. first_negative is 0 when found is 0.
// Words that close no full window give no result word.
// Configuration: APB-style port, window_size at byte address 0 (7 bits, 0 acts as 1,
// values above WINDOW_MAX act as WINDOW_MAX). pready is tied high.
// Each word passes the front classify stages, the queue and the result register. Throughput:
// one word per cycle while full is low, set by the two-stage classify pipeline and the single
// ring read port in the back end; every stage takes one word a cycle when not stalled.
// When the consumer stalls, the result word holds and the two-entry queue fills; full
// rises as soon as the queue holds two words, and the two front stages hold in place.
// Reset: pointer, fill count, sign mask and all valid flags clear and window_size
// returns to 1; the value ring needs no clearing, so a word may be pushed straight away.
// Depends on swfn_pkg, swfn_front, swfn_queue and swfn_back.
module sliding_window_first_negative #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [swfn_pkg::ADDR_W-1:0]  paddr,
    input  logic        [swfn_pkg::APB_W-1:0]   pwdata,
    output logic        [swfn_pkg::APB_W-1:0]   prdata,
    output logic                                pready,
    input  logic signed [swfn_pkg::DATA_W-1:0]  sample,
    input  logic                                push,
    output logic                                full,
    output logic                                found,
    output logic signed [swfn_pkg::DATA_W-1:0]  first_negative,
    output logic                                empty,
    input  logic                                pop
);

    localparam int RING   = WINDOW_MAX + swfn_pkg::RING_SLACK;
    localparam int IDX_W  = $clog2(RING);
    localparam int NGRP   = (RING + swfn_pkg::GRP_SIZE - 1) / swfn_pkg::GRP_SIZE;
    localparam int Q_W    = 1 + 2 * NGRP * (1 + swfn_pkg::LOC_W);

    logic [swfn_pkg::CFG_W-1:0] window_size_reg;
    logic                       cfg_wr;
    logic                       reg_sel;

    logic                       ring_we;
    logic [IDX_W-1:0]           ring_waddr;
    logic                       fq_valid;
    logic                       fq_ready;
    logic [Q_W-1:0]             fq_data;
    logic                       qb_valid;
    logic                       qb_ready;
    logic [Q_W-1:0]             qb_data;

    assign pready  = 1'b1;
    assign reg_sel = paddr[swfn_pkg::ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_size_reg <= swfn_pkg::WINDOW_SIZE_RESET;
        else if (cfg_wr && reg_sel == swfn_pkg::REG_WINDOW_SIZE)
            window_size_reg <= pwdata[swfn_pkg::CFG_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == swfn_pkg::REG_WINDOW_SIZE)
            prdata = swfn_pkg::APB_W'(window_size_reg);
    end

    swfn_front #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .push        (push),
        .full        (full),
        .window_size (window_size_reg),
        .ring_we     (ring_we),
        .ring_waddr  (ring_waddr),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_data      (fq_data)
    );

    swfn_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    swfn_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .q_data         (qb_data),
        .ring_we        (ring_we),
        .ring_waddr     (ring_waddr),
        .ring_wdata     (sample),
        .empty          (empty),
        .pop            (pop),
        .found          (found),
        .first_negative (first_negative)
    );

endmodule

@@ sim/sliding_window_first_negative_tb.sv @@
// Testbench for sliding_window_first_negative: drives a signed sample stream and checks
// each window result against a predictor of the ring and its sign bits.
// Depends on swfn_pkg and the sliding_window_first_negative RTL.
module sliding_window_first_negative_tb;

    localparam int RING_DEPTH    = 64;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 3000;

    localparam logic [swfn_pkg::ADDR_W-1:0] ADDR_WINDOW_SIZE =
        {swfn_pkg::REG_WINDOW_SIZE, 2'b00};
    localparam logic [swfn_pkg::ADDR_W-1:0] ADDR_SPARE       = 3'd4;

    typedef struct packed {
        logic                               found;
        logic signed [swfn_pkg::DATA_W-1:0] first_neg;
    } window_result_t;

    logic                               clk     = 1'b0;
    logic                               rst_n   = 1'b0;
    logic                               psel    = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite  = 1'b0;
    logic        [swfn_pkg::ADDR_W-1:0] paddr   = '0;
    logic        [swfn_pkg::APB_W-1:0]  pwdata  = '0;
    logic        [swfn_pkg::APB_W-1:0]  prdata;
    logic                               pready;
    logic signed [swfn_pkg::DATA_W-1:0] sample  = '0;
    logic                               push    = 1'b0;
    logic                               full;
    logic                               found;
    logic signed [swfn_pkg::DATA_W-1:0] first_negative;
    logic                               empty;
    logic                               pop     = 1'b0;

    logic signed [swfn_pkg::DATA_W-1:0] sample_backlog[$];
    window_result_t                     window_results_due[$];

    logic signed [swfn_pkg::DATA_W-1:0] history[RING_DEPTH];
    logic [RING_DEPTH-1:0]              neg_flags    = '0;
    int                                 head         = 0;
    int                                 held         = 0;
    logic [swfn_pkg::CFG_W-1:0]         window_reg   = swfn_pkg::WINDOW_SIZE_RESET;

    int   send_idle_pct  = 0;
    int   pop_stall_pct  = 0;
    logic hold_arm       = 1'b0;
    int   hold_spent     = 0;
    int   samples_queued = 0;
    int   samples_taken  = 0;
    int   windows_checked = 0;
    int   full_stalls    = 0;
    int   settings_used  = 0;
    int   mismatches     = 0;
    int   quiet          = 0;

    sliding_window_first_negative uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .sample         (sample),
        .push           (push),
        .full           (full),
        .found          (found),
        .first_negative (first_negative),
        .empty          (empty),
        .pop            (pop)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the ring by one word and queue the window result if the window is full.
    function automatic void slide_window(input logic signed [swfn_pkg::DATA_W-1:0] s);
        int             span;
        int             slot;
        window_result_t r;
        history[head]   = s;
        neg_flags[head] = s[swfn_pkg::DATA_W-1];
        head            = (head + 1) % RING_DEPTH;
        if (held < RING_DEPTH)
            held++;
        span = (window_reg == 0) ? 1 : (window_reg > RING_DEPTH) ? RING_DEPTH : window_reg;
        if (held < span)
            return;
        r.found     = 1'b0;
        r.first_neg = '0;
        for (int k = 0; k < span; k++)
        begin
            slot = (head + RING_DEPTH - span + k) % RING_DEPTH;
            if (neg_flags[slot])
            begin
                r.found     = 1'b1;
                r.first_neg = history[slot];
                break;
            end
        end
        window_results_due.push_back(r);
    endfunction

    function automatic logic signed [swfn_pkg::DATA_W-1:0] random_sample(input int neg_pct);
        logic [swfn_pkg::DATA_W-1:0] v;
        v = $urandom;
        case ($urandom_range(19))
            0: v[swfn_pkg::DATA_W-2:0] = '0;
            1: v[swfn_pkg::DATA_W-2:0] = '1;
            default: ;
        endcase
        v[swfn_pkg::DATA_W-1] = ($urandom_range(99) < neg_pct);
        return v;
    endfunction

    // Sender: hold the word until taken, then offer the next or idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                slide_window(sample);
                samples_taken++;
            end
            if (push && full)
                full_stalls++;
            if (!push || !full)
            begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push   <= 1'b1;
                    sample <= sample_backlog.pop_front();
                end
                else
                begin
                    push   <= 1'b0;
                    sample <= $urandom;
                end
            end
        end
    end

    // Receiver: compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (window_results_due.size() == 0)
                begin
                    $error("unexpected result word: found %0d, first_negative %0d",
                           found, first_negative);
                    mismatches++;
                end
                else
                begin
                    want = window_results_due.pop_front();
                    windows_checked++;
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        mismatches++;
                    end
                    if (first_negative !== want.first_neg)
                    begin
                        $error("first_negative: expected %0d, got %0d",
                               want.first_neg, first_negative);
                        mismatches++;
                    end
                end
            end
            if (hold_arm && hold_spent < HOLD_CYCLES)
            begin
                pop <= 1'b0;
                hold_spent++;
            end
            else
                pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (psel && penable))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [swfn_pkg::ADDR_W-1:0] addr,
                              input logic [swfn_pkg::APB_W-1:0] data,
                              output logic [swfn_pkg::APB_W-1:0] rd);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd      = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_window_reg();
        logic [swfn_pkg::APB_W-1:0] rd;
        apb_access(1'b0, ADDR_WINDOW_SIZE, '0, rd);
        if (rd[swfn_pkg::CFG_W-1:0] !== window_reg)
        begin
            $error("window_size: expected %0d, got %0d", window_reg,
                   rd[swfn_pkg::CFG_W-1:0]);
            mismatches++;
        end
    endtask

    task automatic set_window(input int win);
        logic [swfn_pkg::APB_W-1:0] rd;
        logic [swfn_pkg::APB_W-1:0] wdata;
        wdata                      = $urandom;
        wdata[swfn_pkg::CFG_W-1:0] = win[swfn_pkg::CFG_W-1:0];
        apb_access(1'b1, ADDR_WINDOW_SIZE, wdata, rd);
        window_reg = win[swfn_pkg::CFG_W-1:0];
        settings_used++;
        check_window_reg();
    endtask

    task automatic offer(input logic signed [swfn_pkg::DATA_W-1:0] s);
        sample_backlog.push_back(s);
        samples_queued++;
    endtask

    task automatic drain();
        while (samples_taken != samples_queued || window_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int win, input int idle_send, input int stall_pop,
                             input int neg_pct, input int count, input bit press);
        drain();
        send_idle_pct = idle_send;
        pop_stall_pct = stall_pop;
        set_window(win);
        if (press)
            hold_arm <= 1'b1;
        for (int i = 0; i < count; i++)
            offer(random_sample(neg_pct));
    endtask

    initial
    begin
        logic [swfn_pkg::APB_W-1:0] rd;
        int                         idle_s;
        int                         idle_p;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_window_reg();

        // Window not yet full: the first five words give nothing.
        set_window(6);
        offer(7);
        offer(-1);
        offer(2);
        offer(-3);
        offer(0);
        offer(5);
        drain();

        // A write to an unmapped register must leave window_size alone.
        apb_access(1'b1, ADDR_SPARE, $urandom, rd);
        check_window_reg();

        // Window size zero acts as one.
        set_window(0);
        offer(32'sh8000_0000);
        offer(32'sh7FFF_FFFF);
        offer(0);
        offer(-1);
        offer(1);
        drain();

        set_window(2);
        offer(1);
        offer(2);
        offer(32'sh8000_0000);

        run_phase(1,   0,  0,  50, 150, 1'b0);
        run_phase(3,   85, 0,  30, 150, 1'b0);
        run_phase(64,  0,  85, 2,  150, 1'b0);
        run_phase(127, 11, 11, 1,  150, 1'b0);
        run_phase(0,   0,  0,  50, 100, 1'b0);
        run_phase(16,  0,  0,  20, 250, 1'b1);
        run_phase(65,  0,  85, 3,  120, 1'b0);
        run_phase(100, 85, 0,  5,  100, 1'b0);
        for (int p = 0; p < 3; p++)
        begin
            case ($urandom_range(3))
                0: begin idle_s = 0;  idle_p = 0;  end
                1: begin idle_s = 85; idle_p = 0;  end
                2: begin idle_s = 0;  idle_p = 85; end
                default: begin idle_s = 11; idle_p = 11; end
            endcase
            run_phase($urandom_range(127), idle_s, idle_p, $urandom_range(60), 130, 1'b0);
        end

        drain();
        repeat (10) @(posedge clk);
        $display("streamed %0d samples over %0d window settings, %0d windows checked",
                 samples_taken, settings_used, windows_checked);
        $display("input held back by full for %0d cycles", full_stalls);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
